// ===== sv/phdbm_pkg.sv =====
// Package: shared types, codes, constants and the sample scale table of the bar meter.
`timescale 1ns / 1ps

package phdbm_pkg;

    localparam int MAX_COLUMNS_DEF = 16;

    localparam int LEVEL_W  = 17;
    localparam int HOLD_W   = 16;
    localparam int RATE_W   = 16;
    localparam int CANVAS_W = 10;
    localparam int CFG_W    = 16;
    localparam int XPOS_W   = 14;
    localparam int PROD_W   = 33;

    localparam logic [RATE_W-1:0]   DECAY_RATE_RST    = 16'd138;
    localparam logic [HOLD_W-1:0]   HOLD_TIME_RST     = 16'd500;
    localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 10'd256;
    localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 10'd64;

    localparam logic [3:0]          RAW_MAX  = 4'd9;
    localparam logic [CANVAS_W-1:0] SEP_W    = 10'd4;

    typedef enum logic [2:0] {
        OP_SAMPLE = 3'd0,
        OP_TICK   = 3'd1,
        OP_RESIZE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_RENDER = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_DECAY_RATE    = 2'd0,
        CFG_HOLD_TIME     = 2'd1,
        CFG_CANVAS_WIDTH  = 2'd2,
        CFG_CANVAS_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMPLE_RD,
        S_SAMPLE_WR,
        S_TICK_MUL,
        S_TICK_RD,
        S_TICK_WR,
        S_DIV,
        S_REN_RD,
        S_REN_MUL,
        S_REN_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [3:0]        column;
        logic signed [7:0] level;
        logic [4:0]        count;
        logic [15:0]       delta_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          out_column;
        logic [XPOS_W-1:0]   x_pos;
        logic [CANVAS_W-1:0] y_top;
        logic [CANVAS_W-1:0] draw_width;
        logic [CANVAS_W-1:0] bar_height;
        logic                separator;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [HOLD_W-1:0]  hold;
    } entry_t;

    // floor(raw * 65536 / 9) for raw already clamped to 0..9
    function automatic logic [LEVEL_W-1:0] q16_of_raw(input logic [3:0] raw);
        logic [LEVEL_W-1:0] q;
        begin
            unique case (raw)
                4'd0:    q = 17'd0;
                4'd1:    q = 17'd7281;
                4'd2:    q = 17'd14563;
                4'd3:    q = 17'd21845;
                4'd4:    q = 17'd29127;
                4'd5:    q = 17'd36408;
                4'd6:    q = 17'd43690;
                4'd7:    q = 17'd50972;
                4'd8:    q = 17'd58254;
                default: q = 17'd65536;
            endcase
            return q;
        end
    endfunction

endpackage

// ===== sv/phdbm_if.sv =====
// Interfaces: input item channel and render result channel.
`timescale 1ns / 1ps

interface phdbm_in_if;
    logic                 valid;
    logic                 ready;
    phdbm_pkg::in_item_t  data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface phdbm_out_if;
    logic                 valid;
    logic                 ready;
    phdbm_pkg::out_item_t data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/peak_hold_decay_bar_meter_top.sv =====
// Top level: bar meter sequencer, configuration registers and output register.
`timescale 1ns / 1ps

// Peak-hold bar meter for up to MAX_COLUMNS columns. Items run one at a time
// through a small sequencer around one column store read port, one shared
// multiplier and a bit-serial divider. A sample reads and then writes its column,
// a resize or clear acts as it is taken, a tick walks the N active columns after
// one multiply and a render walks them after the canvas_width / N division,
// waiting while the result sink stalls. Each column costs one store read and, on
// render, one pass through the multiplier. in_ch.ready is high only between
// items; a finished render result waits in the output register while the next
// item is taken.
module peak_hold_decay_bar_meter_top #(
    parameter int MAX_COLUMNS = phdbm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    phdbm_in_if.sink                            in_ch,
    phdbm_out_if.source                         out_ch,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [phdbm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LW = phdbm_pkg::LEVEL_W;
    localparam int HW = phdbm_pkg::HOLD_W;
    localparam int VW = phdbm_pkg::CANVAS_W;

    // configuration
    logic [phdbm_pkg::RATE_W-1:0] decay_rate_reg;
    logic [HW-1:0]                hold_time_reg;
    logic [VW-1:0]                canvas_width_reg;
    logic [VW-1:0]                canvas_height_reg;

    // control
    phdbm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     active_reg, active_next;
    logic              out_valid_reg;

    // payload
    logic [3:0]                   col_reg;
    logic [LW-1:0]                q_reg;
    logic [HW-1:0]                delta_reg;
    logic [VW-1:0]                colw_reg;
    logic [VW-1:0]                draww_reg;
    logic                         sep_reg;
    logic [phdbm_pkg::XPOS_W-1:0] x_reg;
    phdbm_pkg::out_item_t         out_data_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 idx_last;
    logic [AW+3:0]        col_ext;
    logic [AW-1:0]        col_addr;
    logic [CW-1:0]        cnt_sat;
    logic [3:0]           raw_clamp;

    logic [AW-1:0]        rd_addr;
    phdbm_pkg::entry_t    rd_data;
    logic                 wr_en;
    phdbm_pkg::entry_t    wr_data;
    logic                 clr_all;
    logic                 clr_range;

    logic                        mul_en;
    logic                        mul_tick;
    logic [LW-1:0]               mul_a;
    logic [phdbm_pkg::RATE_W-1:0] mul_b;
    logic [phdbm_pkg::PROD_W-1:0] mul_p;

    logic                 div_start;
    logic                 div_done;
    logic [VW-1:0]        div_q;
    logic [VW-1:0]        colw_cand;
    logic [VW-1:0]        colw_calc;

    logic [31:0]          dec;
    phdbm_pkg::entry_t    tick_entry;
    logic [VW:0]          h_full;
    logic [VW-1:0]        y_calc;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg    <= phdbm_pkg::DECAY_RATE_RST;
            hold_time_reg     <= phdbm_pkg::HOLD_TIME_RST;
            canvas_width_reg  <= phdbm_pkg::CANVAS_WIDTH_RST;
            canvas_height_reg <= phdbm_pkg::CANVAS_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (phdbm_pkg::cfg_idx_t'(cfg_index))
                phdbm_pkg::CFG_DECAY_RATE:    decay_rate_reg    <= cfg_data;
                phdbm_pkg::CFG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                phdbm_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[VW-1:0];
                phdbm_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == phdbm_pkg::S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign idx_last    = (idx_reg + CW'(1)) == active_reg;
    assign col_ext     = (AW + 4)'(col_reg);
    assign col_addr    = col_ext[AW-1:0];

    // clamp negative to 0 and large to 9
    always_comb
    begin
        if (in_ch.data.level[7])
        begin
            raw_clamp = 4'd0;
        end
        else if (in_ch.data.level[6:0] > 7'(phdbm_pkg::RAW_MAX))
        begin
            raw_clamp = phdbm_pkg::RAW_MAX;
        end
        else
        begin
            raw_clamp = in_ch.data.level[3:0];
        end
    end

    always_comb
    begin
        if (int'(in_ch.data.count) > MAX_COLUMNS)
        begin
            cnt_sat = CW'(MAX_COLUMNS);
        end
        else
        begin
            cnt_sat = CW'(in_ch.data.count);
        end
    end

    // column width: (canvas_width / n) rounded down to a multiple of 4, at least 4
    assign colw_cand = {div_q[VW-1:2], 2'b00};
    assign colw_calc = (colw_cand < phdbm_pkg::SEP_W) ? phdbm_pkg::SEP_W : colw_cand;

    // tick arithmetic on the entry just read
    assign dec = mul_p[31:0];
    always_comb
    begin
        tick_entry = rd_data;
        if (rd_data.hold != '0)
        begin
            tick_entry.hold = (rd_data.hold > delta_reg) ? (rd_data.hold - delta_reg) : '0;
        end
        else if (dec >= 32'(rd_data.level))
        begin
            tick_entry.level = '0;
        end
        else
        begin
            tick_entry.level = rd_data.level - dec[LW-1:0];
        end
    end

    // render geometry from the registered product
    assign h_full = mul_p[LW+VW-1:LW-1];
    assign y_calc = ({1'b0, canvas_height_reg} >= h_full)
                  ? VW'({1'b0, canvas_height_reg} - h_full) : '0;

    assign mul_tick = (state_reg == phdbm_pkg::S_TICK_MUL);
    assign mul_a    = mul_tick ? LW'(decay_rate_reg) : rd_data.level;
    assign mul_b    = mul_tick ? delta_reg : phdbm_pkg::RATE_W'(canvas_height_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_data     = tick_entry;
        clr_all     = 1'b0;
        clr_range   = 1'b0;
        div_start   = 1'b0;
        mul_en      = 1'b0;
        load_out    = 1'b0;

        unique case (state_reg)
            phdbm_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    unique case (phdbm_pkg::op_t'(in_ch.data.opcode))
                        phdbm_pkg::OP_SAMPLE:
                        begin
                            if ((CW + 4)'(in_ch.data.column) < (CW + 4)'(active_reg))
                            begin
                                state_next = phdbm_pkg::S_SAMPLE_RD;
                            end
                        end
                        phdbm_pkg::OP_TICK:
                        begin
                            if (active_reg != '0)
                            begin
                                state_next = phdbm_pkg::S_TICK_MUL;
                            end
                        end
                        phdbm_pkg::OP_RESIZE:
                        begin
                            if (in_ch.data.count != '0)
                            begin
                                clr_range   = 1'b1;
                                active_next = cnt_sat;
                            end
                        end
                        phdbm_pkg::OP_CLEAR:
                        begin
                            clr_all     = 1'b1;
                            active_next = '0;
                        end
                        phdbm_pkg::OP_RENDER:
                        begin
                            if (active_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = phdbm_pkg::S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            phdbm_pkg::S_SAMPLE_RD:
            begin
                rd_addr    = col_addr;
                state_next = phdbm_pkg::S_SAMPLE_WR;
            end
            phdbm_pkg::S_SAMPLE_WR:
            begin
                // replace on a level at or above the stored one and reload the hold
                if (q_reg >= rd_data.level)
                begin
                    wr_en         = 1'b1;
                    wr_data.level = q_reg;
                    wr_data.hold  = hold_time_reg;
                end
                state_next = phdbm_pkg::S_IDLE;
            end
            phdbm_pkg::S_TICK_MUL:
            begin
                mul_en     = 1'b1;
                state_next = phdbm_pkg::S_TICK_RD;
            end
            phdbm_pkg::S_TICK_RD:
            begin
                state_next = phdbm_pkg::S_TICK_WR;
            end
            phdbm_pkg::S_TICK_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + CW'(1);
                state_next = idx_last ? phdbm_pkg::S_IDLE : phdbm_pkg::S_TICK_RD;
            end
            phdbm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = phdbm_pkg::S_REN_RD;
                end
            end
            phdbm_pkg::S_REN_RD:
            begin
                state_next = phdbm_pkg::S_REN_MUL;
            end
            phdbm_pkg::S_REN_MUL:
            begin
                mul_en     = 1'b1;
                state_next = phdbm_pkg::S_REN_OUT;
            end
            phdbm_pkg::S_REN_OUT:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    load_out   = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                    state_next = idx_last ? phdbm_pkg::S_IDLE : phdbm_pkg::S_REN_RD;
                end
            end
            default:
            begin
                state_next = phdbm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phdbm_pkg::S_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg   <= in_ch.data.column;
            q_reg     <= phdbm_pkg::q16_of_raw(raw_clamp);
            delta_reg <= in_ch.data.delta_ms;
            x_reg     <= '0;
        end
        else if (load_out)
        begin
            x_reg <= x_reg + phdbm_pkg::XPOS_W'(colw_reg);
        end

        if (div_done)
        begin
            colw_reg  <= colw_calc;
            sep_reg   <= colw_calc > phdbm_pkg::SEP_W;
            draww_reg <= (colw_calc > phdbm_pkg::SEP_W) ? (colw_calc - phdbm_pkg::SEP_W)
                                                        : colw_calc;
        end

        if (load_out)
        begin
            out_data_reg.out_column <= 4'(idx_reg);
            out_data_reg.x_pos      <= x_reg;
            out_data_reg.y_top      <= y_calc;
            out_data_reg.draw_width <= draww_reg;
            out_data_reg.bar_height <= h_full[VW-1:0];
            out_data_reg.separator  <= sep_reg;
            out_data_reg.last       <= idx_last;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    phdbm_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW),
        .CW    (CW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   ((state_reg == phdbm_pkg::S_SAMPLE_WR) ? col_addr : idx_reg[AW-1:0]),
        .wr_data   (wr_data),
        .clr_all   (clr_all),
        .clr_range (clr_range),
        .clr_lo    (active_reg),
        .clr_hi    (cnt_sat)
    );

    phdbm_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    phdbm_div #(
        .DW (VW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (canvas_width_reg),
        .divisor  (active_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // resize saturates the column count
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(active_reg) <= MAX_COLUMNS)
        else $error("active column count above maximum");

    // divider finishes only while the render waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == phdbm_pkg::S_DIV))
        else $error("divider done outside division wait");

    // column walk stays inside the active columns
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == phdbm_pkg::S_TICK_WR || state_reg == phdbm_pkg::S_REN_OUT)
        |-> (idx_reg < active_reg))
        else $error("column index beyond active columns");

    // the final render beat returns the sequencer to idle
    a_last_ends_render: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && idx_last) |=> (state_reg == phdbm_pkg::S_IDLE))
        else $error("render did not end after last column");

endmodule

// ===== sv/phdbm_store.sv =====
// Column store: level and hold timer per column, registered read, per-entry valid bits.
`timescale 1ns / 1ps

module phdbm_store #(
    parameter int DEPTH = phdbm_pkg::MAX_COLUMNS_DEF,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [AW-1:0]       rd_addr,
    output phdbm_pkg::entry_t   rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  phdbm_pkg::entry_t   wr_data,
    input  logic                clr_all,
    input  logic                clr_range,
    input  logic [CW-1:0]       clr_lo,
    input  logic [CW-1:0]       clr_hi
);

    phdbm_pkg::entry_t entry_mem [DEPTH];
    phdbm_pkg::entry_t data_reg;
    logic              rd_vld_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        data_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_next[i] = valid_reg[i];
            if (clr_all)
            begin
                valid_next[i] = 1'b0;
            end
            else if (clr_range && (CW'(i) >= clr_lo) && (CW'(i) < clr_hi))
            begin
                valid_next[i] = 1'b0;
            end
            else if (wr_en && (wr_addr == AW'(i)))
            begin
                valid_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // an entry never written since reset or clear reads as zero
    assign rd_data = rd_vld_reg ? data_reg : '0;

endmodule

// ===== sv/phdbm_mul.sv =====
// Shared multiplier: one registered unsigned product, loaded on enable.
`timescale 1ns / 1ps

module phdbm_mul (
    input  logic                             clk,
    input  logic                             en,
    input  logic [phdbm_pkg::LEVEL_W-1:0]    a,
    input  logic [phdbm_pkg::RATE_W-1:0]     b,
    output logic [phdbm_pkg::PROD_W-1:0]     p
);

    logic [phdbm_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= phdbm_pkg::PROD_W'(a) * phdbm_pkg::PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/phdbm_div.sv =====
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module phdbm_div #(
    parameter int DW = phdbm_pkg::CANVAS_W,
    parameter int VW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CTW = $clog2(DW + 1);

    logic [DW-1:0]  quo_reg;
    logic [VW-1:0]  rem_reg;
    logic [CTW-1:0] cnt_reg;
    logic           done_reg;
    logic [VW:0]    rem_sh;
    logic           fits;

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign fits   = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(rem_sh - {1'b0, divisor}) : VW'(rem_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CTW'(1)) && !start;
            if (start)
            begin
                cnt_reg <= CTW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CTW'(1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the peak-hold bar meter: directed script, random traffic, bar prediction.
`timescale 1ns / 1ps

module tb_top;
    import phdbm_pkg::*;

    localparam int          MAX_COLS     = MAX_COLUMNS_DEF;
    localparam int unsigned Q16_ONE      = 65536;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          MAX_REPORTS  = 10;
    localparam int          BLOCKS       = 8;
    localparam int          BLOCK_BEATS  = 62;

    // opcodes the block has no use for
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t bar;
    } script_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    phdbm_in_if  in_ch();
    phdbm_out_if out_ch();

    peak_hold_decay_bar_meter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // meter state as the block should hold it
    logic [LEVEL_W-1:0]  lvl_q16 [MAX_COLS];
    logic [HOLD_W-1:0]   hold_ms [MAX_COLS];
    int unsigned         n_active;
    logic [RATE_W-1:0]   decay_per_ms;
    logic [HOLD_W-1:0]   hold_reload;
    logic [CANVAS_W-1:0] width_px;
    logic [CANVAS_W-1:0] height_px;

    out_item_t   bars_due [$];
    script_row_t script [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int bar_errs = 0;
    int bars_seen = 0;
    int beats_in = 0;
    int settings_used = 1;

    function automatic void reset_meter();
        for (int i = 0; i < MAX_COLS; i++)
        begin
            lvl_q16[i] = '0;
            hold_ms[i] = '0;
        end
        n_active     = 0;
        decay_per_ms = DECAY_RATE_RST;
        hold_reload  = HOLD_TIME_RST;
        width_px     = CANVAS_WIDTH_RST;
        height_px    = CANVAS_HEIGHT_RST;
    endfunction

    // advance the meter by one accepted beat, queue the bars it renders
    function automatic void meter_step(input in_item_t it);
        int unsigned       raw;
        int unsigned       q;
        int unsigned       cnt;
        int unsigned       colw;
        int unsigned       draww;
        int unsigned       hgt;
        longint unsigned   prod;
        out_item_t         bar;
        case (it.opcode)
            OP_SAMPLE:
            begin
                if (it.column < n_active)
                begin
                    raw = it.level[7] ? 0 : int'(it.level[6:0]);
                    if (raw > 32'(RAW_MAX))
                        raw = 32'(RAW_MAX);
                    q = (raw * Q16_ONE) / 32'(RAW_MAX);
                    if (q >= 32'(lvl_q16[it.column]))
                    begin
                        lvl_q16[it.column] = LEVEL_W'(q);
                        hold_ms[it.column] = hold_reload;
                    end
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < n_active; i++)
                begin
                    if (hold_ms[i] != 0)
                        hold_ms[i] = (hold_ms[i] > it.delta_ms) ? hold_ms[i] - it.delta_ms : '0;
                    else
                    begin
                        prod = longint'(decay_per_ms) * longint'(it.delta_ms);
                        lvl_q16[i] = (prod >= 64'(lvl_q16[i])) ? '0
                                   : LEVEL_W'(64'(lvl_q16[i]) - prod);
                    end
                end
            end
            OP_RESIZE:
            begin
                if (it.count != 0)
                begin
                    cnt = (int'(it.count) > MAX_COLS) ? MAX_COLS : int'(it.count);
                    for (int i = n_active; i < cnt; i++)
                    begin
                        lvl_q16[i] = '0;
                        hold_ms[i] = '0;
                    end
                    n_active = cnt;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < MAX_COLS; i++)
                begin
                    lvl_q16[i] = '0;
                    hold_ms[i] = '0;
                end
                n_active = 0;
            end
            OP_RENDER:
            begin
                if (n_active != 0)
                begin
                    colw = (int'(width_px) / n_active) / int'(SEP_W) * int'(SEP_W);
                    if (colw < 32'(SEP_W))
                        colw = 32'(SEP_W);
                    draww = (colw > 32'(SEP_W)) ? colw - 32'(SEP_W) : colw;
                    for (int i = 0; i < n_active; i++)
                    begin
                        prod = longint'(lvl_q16[i]) * longint'(height_px);
                        hgt  = 32'(prod >> 16);
                        bar.out_column = 4'(i);
                        bar.x_pos      = XPOS_W'(i * colw);
                        bar.y_top      = (32'(height_px) >= hgt)
                                       ? CANVAS_W'(32'(height_px) - hgt) : '0;
                        bar.draw_width = CANVAS_W'(draww);
                        bar.bar_height = CANVAS_W'(hgt);
                        bar.separator  = (colw > 32'(SEP_W));
                        bar.last       = (i + 1 == n_active);
                        bars_due.push_back(bar);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t mk(input logic [2:0] op, input int col, input int lvl,
                                    input int cnt, input int ms);
        in_item_t it;
        it.opcode   = op;
        it.column   = 4'(col);
        it.level    = 8'(lvl);
        it.count    = 5'(cnt);
        it.delta_ms = 16'(ms);
        return it;
    endfunction

    function automatic void add_row(input in_item_t it);
        script.push_back('{it, 1'b0, '0});
    endfunction

    function automatic void build_script();
        add_row(mk(OP_RENDER, 0, 0, 0, 0));           // no columns yet: nothing rendered
        add_row(mk(OP_SAMPLE, 0, 9, 0, 0));           // column not active: dropped
        add_row(mk(OP_RESIZE, 0, 0, 0, 0));           // zero count: dropped
        add_row(mk(OP_RESIZE, 0, 0, 1, 0));
        add_row(mk(OP_SAMPLE, 0, 127, 0, 0));         // clamps to full scale
        script.push_back('{mk(OP_RENDER, 0, 0, 0, 0), 1'b1,
                           '{4'd0, 14'd0, 10'd0, 10'd252, 10'd64, 1'b1, 1'b1}});
        add_row(mk(OP_TICK, 0, 0, 0, 499));
        add_row(mk(OP_TICK, 0, 0, 0, 65535));         // hold runs out, no decay yet
        add_row(mk(OP_TICK, 0, 0, 0, 0));
        add_row(mk(OP_SAMPLE, 0, -128, 0, 0));        // below current level: no effect
        add_row(mk(OP_TICK, 0, 0, 0, 65535));         // decay saturates at zero
        script.push_back('{mk(OP_RENDER, 0, 0, 0, 0), 1'b1,
                           '{4'd0, 14'd0, 10'd64, 10'd252, 10'd0, 1'b1, 1'b1}});
        add_row(mk(OP_RESIZE, 0, 0, 31, 0));          // saturates to the maximum
        add_row(mk(OP_SAMPLE, 15, 5, 0, 0));
        add_row(mk(OP_SAMPLE, 0, 0, 0, 0));           // equal level still reloads hold
        add_row(mk(OP_SAMPLE, 7, 8, 0, 0));
        add_row(mk(OP_RENDER, 0, 0, 0, 0));
        add_row(mk(OP_RESIZE, 0, 0, 4, 0));           // shrink keeps levels
        add_row(mk(OP_RESIZE, 0, 0, 16, 0));          // grow clears the new columns
        add_row(mk(OP_RENDER, 0, 0, 0, 0));
        add_row(mk(OP_RSVD5, 15, -1, 31, 65535));
        add_row(mk(OP_RSVD6, 10, 85, 21, 43690));
        add_row(mk(OP_RSVD7, 5, -86, 10, 21845));
        add_row(mk(OP_CLEAR, 0, 0, 0, 0));
        add_row(mk(OP_RENDER, 0, 0, 0, 0));
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int       pick;
        it.column   = 4'($urandom);
        it.level    = 8'($urandom);
        it.count    = 5'($urandom);
        it.delta_ms = 16'($urandom);
        pick = int'($urandom_range(99));
        // with no columns only a resize gets anywhere
        if (n_active == 0 && pick < 70)
            pick = 85;
        if (pick < 45)
        begin
            it.opcode = OP_SAMPLE;
            if (pick < 40 && n_active != 0)
                it.column = 4'($urandom_range(n_active - 1));
            if ($urandom_range(3) != 0)
                it.level = 8'($urandom_range(RAW_MAX));
        end
        else if (pick < 70)
        begin
            it.opcode = OP_TICK;
            case ($urandom_range(3))
                0: it.delta_ms = 16'($urandom_range(5));
                1: it.delta_ms = 16'($urandom_range(200));
                2: it.delta_ms = 16'($urandom_range(2000));
                default: ;
            endcase
        end
        else if (pick < 82)
            it.opcode = OP_RENDER;
        else if (pick < 93)
        begin
            it.opcode = OP_RESIZE;
            if ($urandom_range(4) != 0)
                it.count = 5'($urandom_range(MAX_COLS, 1));
        end
        else if (pick < 95)
            it.opcode = OP_CLEAR;
        else
            it.opcode = 3'($urandom_range(OP_RSVD7, OP_RSVD5));
        return it;
    endfunction

    task automatic drive_item(input in_item_t it, input bit typed, input out_item_t bar);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (typed)
            bars_due.push_back(bar);
        else
            meter_step(it);
        beats_in++;
    endtask

    // drop valid, drain every bar, then let trailing ticks finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (bars_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DECAY_RATE:    decay_per_ms = val;
            CFG_HOLD_TIME:     hold_reload  = val;
            CFG_CANVAS_WIDTH:  width_px     = val[CANVAS_W-1:0];
            CFG_CANVAS_HEIGHT: height_px    = val[CANVAS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [RATE_W-1:0] dr, input logic [HOLD_W-1:0] ht,
                             input logic [CANVAS_W-1:0] cw, input logic [CANVAS_W-1:0] ch);
        wait_idle();
        write_reg(CFG_DECAY_RATE, dr);
        write_reg(CFG_HOLD_TIME, ht);
        write_reg(CFG_CANVAS_WIDTH, CFG_W'(cw));
        write_reg(CFG_CANVAS_HEIGHT, CFG_W'(ch));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void check_bar(input out_item_t got);
        out_item_t want;
        if (bars_due.size() == 0)
        begin
            bar_errs++;
            if (bar_errs <= MAX_REPORTS)
                $display("ERROR: bar for column %0d arrived with none pending", got.out_column);
            return;
        end
        want = bars_due.pop_front();
        bars_seen++;
        if (got.out_column !== want.out_column || got.x_pos !== want.x_pos
            || got.y_top !== want.y_top || got.draw_width !== want.draw_width
            || got.bar_height !== want.bar_height || got.separator !== want.separator
            || got.last !== want.last)
        begin
            bar_errs++;
            if (bar_errs <= MAX_REPORTS)
            begin
                $display("ERROR: bar %0d exp col %0d x %0d y %0d w %0d h %0d sep %0d last %0d",
                         bars_seen, want.out_column, want.x_pos, want.y_top, want.draw_width,
                         want.bar_height, want.separator, want.last);
                $display("       got col %0d x %0d y %0d w %0d h %0d sep %0d last %0d",
                         got.out_column, got.x_pos, got.y_top, got.draw_width,
                         got.bar_height, got.separator, got.last);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_bar(out_ch.data);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        int       blk;
        int       beats;
        in_item_t it;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_DECAY_RATE;
        cfg_data     <= '0;
        reset_meter();
        build_script();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
            drive_item(script[k].item, script[k].typed, script[k].bar);

        for (blk = 0; blk < BLOCKS; blk++)
        begin
            case (blk)
                0: load_regs(DECAY_RATE_RST, HOLD_TIME_RST, CANVAS_WIDTH_RST, CANVAS_HEIGHT_RST);
                1: load_regs(16'd0, 16'd0, 10'd4, 10'd1);
                2: load_regs(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023);
                3: load_regs(RATE_W'($urandom_range(300, 1)), HOLD_W'($urandom_range(100)),
                             CANVAS_W'($urandom_range(1023, 4)),
                             CANVAS_W'($urandom_range(1023, 1)));
                4: load_regs(RATE_W'($urandom), HOLD_W'($urandom),
                             CANVAS_W'($urandom_range(1023, 4)),
                             CANVAS_W'($urandom_range(1023, 1)));
                5: load_regs(16'hFFFF, 16'd0, 10'd4, 10'd1023);
                6: load_regs(16'd0, 16'hFFFF, 10'd1023, 10'd1);
                default: load_regs(RATE_W'($urandom_range(50, 1)), HOLD_W'($urandom_range(30)),
                                   CANVAS_W'($urandom_range(1023, 4)),
                                   CANVAS_W'($urandom_range(1023, 1)));
            endcase
            case (blk % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            beats = 0;
            while (beats < BLOCK_BEATS)
            begin
                it = rand_item();
                drive_item(it, 1'b0, '0);
                if (it.opcode <= OP_RENDER)
                    beats++;
            end
        end

        wait_idle();
        $display("Summary: %0d input beats under %0d register settings, %0d bars checked",
                 beats_in, settings_used, bars_seen);
        $display("Summary: %0d mismatching or unexpected bars", bar_errs);
        if (bar_errs == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d bars still pending", bars_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== peak_hold_decay_bar_meter_top.f =====
sv/phdbm_pkg.sv
sv/phdbm_if.sv
sv/phdbm_store.sv
sv/phdbm_mul.sv
sv/phdbm_div.sv
sv/peak_hold_decay_bar_meter_top.sv
tb/tb_top.sv
